// ----- hdl/aspect_fit_scaler_mapper_assert.svh -----
// ----------------------------------------------------------------------------
// aspect fit scaler mapper assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASPECT_FIT_SCALER_MAPPER_ASSERT_SVH
`define ASPECT_FIT_SCALER_MAPPER_ASSERT_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define AFSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define AFSM_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define AFSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define AFSM_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- hdl/afsm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsm_pkg
// shared widths, register indexes, fit status struct and divider step
// ----------------------------------------------------------------------------
package afsm_pkg;

  localparam int unsigned SIDE_W = 13;
  localparam int unsigned OFS_W  = 12;
  localparam int unsigned PROD_W = 2 * SIDE_W;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned IDX_W  = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_VIEW_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_VIEW_HEIGHT = 3'd3;

  // func codes
  localparam logic FUNC_RECT  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // geometry seen by the mapping pipeline
  typedef struct packed {
    logic              busy;
    logic [SIDE_W-1:0] src_width;
    logic [SIDE_W-1:0] src_height;
    logic [SIDE_W-1:0] fitted_width;
    logic [SIDE_W-1:0] fitted_height;
    logic [OFS_W-1:0]  offset_x;
    logic [OFS_W-1:0]  offset_y;
  } fit_t;

  // one restoring division step, remainder below divisor on entry
  // returns {quotient bit, new remainder}
  function automatic logic [SIDE_W:0] div_step(input logic [SIDE_W-1:0] rem,
                                               input logic nbit,
                                               input logic [SIDE_W-1:0] den);
    logic [SIDE_W:0] trial;
    logic [SIDE_W:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[SIDE_W-1:0]};
    end
    return {1'b0, trial[SIDE_W-1:0]};
  endfunction

endpackage

// ----- hdl/afsm_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsm_in_if
// request channel: valid/ready with one mapping request
// ----------------------------------------------------------------------------
interface afsm_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [afsm_pkg::POS_W-1:0]   pos_x;
  logic signed [afsm_pkg::POS_W-1:0]   pos_y;
  logic        [afsm_pkg::POS_W-1:0]   rect_w;
  logic        [afsm_pkg::POS_W-1:0]   rect_h;
  logic                                end_of_batch;

  modport source (output valid, func, pos_x, pos_y, rect_w, rect_h, end_of_batch,
                  input ready);
  modport sink (input valid, func, pos_x, pos_y, rect_w, rect_h, end_of_batch,
                output ready);
endinterface

// ----- hdl/afsm_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsm_out_if
// result channel: valid/ready with one mapping result
// ----------------------------------------------------------------------------
interface afsm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [afsm_pkg::SIDE_W-1:0]   out_x0;
  logic [afsm_pkg::SIDE_W-1:0]   out_y0;
  logic [afsm_pkg::SIDE_W-1:0]   out_x1;
  logic [afsm_pkg::SIDE_W-1:0]   out_y1;
  logic                          batch_done;

  modport source (output valid, status, out_x0, out_y0, out_x1, out_y1, batch_done,
                  input ready);
  modport sink (input valid, status, out_x0, out_y0, out_x1, out_y1, batch_done,
                output ready);
endinterface

// ----- hdl/afsm_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsm_div
// pipelined restoring divider lane, one quotient bit per stage
// ----------------------------------------------------------------------------
module afsm_div (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [afsm_pkg::PROD_W-1:0]   num_i,
  input  logic [afsm_pkg::SIDE_W-1:0]   den_i,
  output logic [afsm_pkg::SIDE_W-1:0]   quo_o,
  output logic                          rem_nz_o
);

  localparam int unsigned SW = afsm_pkg::SIDE_W;

  logic [SW-1:0] rem_q [SW];
  logic [SW-1:0] quo_q [SW];
  logic [SW-1:0] low_q [SW-1];
  logic [SW-1:0] den_q [SW-1];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [SW-1:0] rem_in;
    logic [SW-1:0] low_in;
    logic [SW-1:0] quo_in;
    logic [SW-1:0] den_in;
    logic [SW:0]   step;

    // stage inputs: upper half of the numerator enters as remainder
    if (k == 0) begin : g_first
      assign rem_in = num_i[afsm_pkg::PROD_W-1:SW];
      assign low_in = num_i[SW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign step = afsm_pkg::div_step(rem_in, low_in[SW-1], den_in);

    // remainder and quotient registers
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= step[SW-1:0];
        quo_q[k] <= {quo_in[SW-2:0], step[SW]};
      end
    end

    // numerator bits and divisor travel on to later stages
    if (k < SW - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          low_q[k] <= {low_in[SW-2:0], 1'b0};
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o    = quo_q[SW-1];
  assign rem_nz_o = |rem_q[SW-1];

endmodule

// ----- hdl/afsm_fit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afsm_fit
// configuration registers and the sequential aspect fit of the output box
// ----------------------------------------------------------------------------
`include "aspect_fit_scaler_mapper_assert.svh"

module afsm_fit #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [afsm_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [afsm_pkg::SIDE_W-1:0]   cfg_data_i,
  output afsm_pkg::fit_t                fit_o
);

  localparam int unsigned SW  = afsm_pkg::SIDE_W;
  localparam int unsigned PW  = afsm_pkg::PROD_W;
  localparam int unsigned CW  = $clog2(SW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SEL,
    ST_DIV,
    ST_FIN,
    ST_OFS
  } fit_state_e;

  fit_state_e     state_q;
  logic [SW-1:0]  src_w_q, src_h_q, view_w_q, view_h_q;
  logic [SW-1:0]  fit_w_q, fit_h_q;
  logic [afsm_pkg::OFS_W-1:0] ofs_x_q, ofs_y_q;
  logic           wfill_q;
  logic [CW-1:0]  cnt_q;

  logic [PW-1:0]  prod_a_q, prod_b_q;
  logic [SW-1:0]  rem_q, low_q, quo_q, den_q;

  logic [SW-1:0]  cfg_val;
  logic           cfg_hit;
  logic [SW:0]    step;
  logic [SW-1:0]  fit_side;
  logic [PW-1:0]  sel_num;
  logic [SW-1:0]  slack_x, slack_y;

  // clamp written value into the legal side range
  always_comb begin
    cfg_val = cfg_data_i;
    if (cfg_data_i == '0) begin
      cfg_val = SW'(1);
    end else if (32'(cfg_data_i) > MAX_SIDE) begin
      cfg_val = SW'(MAX_SIDE);
    end
  end

  assign cfg_hit  = cfg_we_i && (cfg_idx_i <= afsm_pkg::REG_VIEW_HEIGHT);
  assign step     = afsm_pkg::div_step(rem_q, low_q[SW-1], den_q);
  assign fit_side = (quo_q == '0) ? SW'(1) : quo_q;
  assign sel_num  = (prod_a_q <= prod_b_q) ? prod_a_q : prod_b_q;
  assign slack_x  = view_w_q - fit_w_q;
  assign slack_y  = view_h_q - fit_h_q;

  // sequencer, registers and fitted box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      src_w_q  <= SW'(640);
      src_h_q  <= SW'(480);
      view_w_q <= SW'(960);
      view_h_q <= SW'(720);
      fit_w_q  <= SW'(960);
      fit_h_q  <= SW'(720);
      ofs_x_q  <= '0;
      ofs_y_q  <= '0;
      wfill_q  <= 1'b0;
      cnt_q    <= '0;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        afsm_pkg::REG_SRC_WIDTH:  src_w_q  <= cfg_val;
        afsm_pkg::REG_SRC_HEIGHT: src_h_q  <= cfg_val;
        afsm_pkg::REG_VIEW_WIDTH: view_w_q <= cfg_val;
        default:                  view_h_q <= cfg_val;
      endcase
      state_q <= ST_MUL;
    end else begin
      case (state_q)
        ST_MUL: begin
          state_q <= ST_SEL;
        end
        ST_SEL: begin
          wfill_q <= prod_a_q <= prod_b_q;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(SW - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (wfill_q) begin
            fit_w_q <= view_w_q;
            fit_h_q <= fit_side;
          end else begin
            fit_w_q <= fit_side;
            fit_h_q <= view_h_q;
          end
          state_q <= ST_OFS;
        end
        ST_OFS: begin
          ofs_x_q <= slack_x[SW-1:1];
          ofs_y_q <= slack_y[SW-1:1];
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // cross products and the shared division step
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_MUL: begin
        prod_a_q <= PW'(view_w_q) * PW'(src_h_q);
        prod_b_q <= PW'(view_h_q) * PW'(src_w_q);
      end
      ST_SEL: begin
        rem_q <= sel_num[PW-1:SW];
        low_q <= sel_num[SW-1:0];
        quo_q <= '0;
        den_q <= (prod_a_q <= prod_b_q) ? src_w_q : src_h_q;
      end
      ST_DIV: begin
        rem_q <= step[SW-1:0];
        low_q <= {low_q[SW-2:0], 1'b0};
        quo_q <= {quo_q[SW-2:0], step[SW]};
      end
      default: begin
      end
    endcase
  end

  assign fit_o.busy          = (state_q != ST_IDLE);
  assign fit_o.src_width     = src_w_q;
  assign fit_o.src_height    = src_h_q;
  assign fit_o.fitted_width  = fit_w_q;
  assign fit_o.fitted_height = fit_h_q;
  assign fit_o.offset_x      = ofs_x_q;
  assign fit_o.offset_y      = ofs_y_q;

  // settled box lies inside the viewport, fills one side of it and is centred horizontally
  `AFSM_ASSERT(a_box_inside, clk_i, rst_ni, (state_q == ST_IDLE) |-> (fit_w_q <= view_w_q && fit_h_q <= view_h_q && fit_w_q != '0 && fit_h_q != '0), "fitted box exceeds viewport")
  `AFSM_ASSERT(a_box_fills, clk_i, rst_ni, (state_q == ST_IDLE) |-> (fit_w_q == view_w_q || fit_h_q == view_h_q), "fitted box fills no viewport side")
  `AFSM_ASSERT(a_box_centred, clk_i, rst_ni, (state_q == ST_IDLE) |-> ((SW'(ofs_x_q) << 1) + fit_w_q == view_w_q || (SW'(ofs_x_q) << 1) + fit_w_q + SW'(1) == view_w_q), "horizontal offset is not half the slack")

endmodule

// ----- hdl/aspect_fit_scaler_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspect_fit_scaler_mapper
// letterbox geometry and nearest neighbour coordinate mapping
// ----------------------------------------------------------------------------
// The block takes one request per clock and returns one result per request,
// in order: an input stage clips or offsets the coordinates, a multiply stage
// forms the products, four 13-stage divider lanes (one quotient bit per stage)
// divide them, and a last stage adds the box offset to rectangle results and
// fills the output register. A stalled output freezes the whole pipeline.
// After a write to a geometry register the box is refitted by one shared
// division step, during which no request is accepted.
`include "aspect_fit_scaler_mapper_assert.svh"

module aspect_fit_scaler_mapper #(
  parameter int unsigned MAX_SIDE = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  afsm_in_if.sink                       in_i,
  afsm_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [afsm_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [afsm_pkg::SIDE_W-1:0]   cfg_data_i
);

  localparam int unsigned SW = afsm_pkg::SIDE_W;
  localparam int unsigned PW = afsm_pkg::PROD_W;
  localparam int unsigned EW = afsm_pkg::POS_W + 2;

  afsm_pkg::fit_t fit;

  logic adv, acc;

  // stage 1: clipped or offset coordinates
  logic          v1_q, fn1_q, eob1_q, st1_q;
  logic [SW-1:0] ax0_q, ax1_q, ay0_q, ay1_q;
  // stage 2: products and divisors
  logic          v2_q, fn2_q, eob2_q, st2_q;
  logic [PW-1:0] nx0_q, nx1_q, ny0_q, ny1_q;
  logic [SW-1:0] dx0_q, dy0_q;
  // side data alongside the divider lanes
  logic          sd_v_q   [SW];
  logic          sd_fn_q  [SW];
  logic          sd_eob_q [SW];
  logic          sd_st_q  [SW];
  // output register
  logic          ov_q, ost_q, oeob_q;
  logic [SW-1:0] ox0_q, oy0_q, ox1_q, oy1_q;

  logic signed [EW-1:0] px, py, x_end, y_end, sx0, sy0, sx1, sy1, dx, dy;
  logic signed [EW-1:0] sw_s, sh_s, fw_s, fh_s;
  logic                 rect_ok, pix_in, st_in;

  logic [SW-1:0] qx0, qx1, qy0, qy1;
  logic          rx1, ry1;
  logic          rx0_unused, ry0_unused;
  logic [SW:0]   cx1, cy1;
  logic [SW-1:0] lx1, ly1;
  logic [SW-1:0] fx0, fy0, fx1, fy1;
  logic          lst_v, lst_fn, lst_st;

  afsm_fit #(.MAX_SIDE(MAX_SIDE)) u_fit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fit_o      (fit)
  );

  // pipeline moves when the output register is free or being taken
  assign adv        = !ov_q || out_o.ready;
  assign in_i.ready = adv && !fit.busy;
  assign acc        = in_i.valid && in_i.ready;

  // clipping against the source and offsetting into the box
  always_comb begin
    px    = $signed({{2{in_i.pos_x[afsm_pkg::POS_W-1]}}, in_i.pos_x});
    py    = $signed({{2{in_i.pos_y[afsm_pkg::POS_W-1]}}, in_i.pos_y});
    sw_s  = $signed({5'b0, fit.src_width});
    sh_s  = $signed({5'b0, fit.src_height});
    fw_s  = $signed({5'b0, fit.fitted_width});
    fh_s  = $signed({5'b0, fit.fitted_height});
    x_end = px + $signed({2'b0, in_i.rect_w});
    y_end = py + $signed({2'b0, in_i.rect_h});
    sx0   = px[EW-1] ? '0 : px;
    sy0   = py[EW-1] ? '0 : py;
    sx1   = (x_end > sw_s) ? sw_s : x_end;
    sy1   = (y_end > sh_s) ? sh_s : y_end;
    dx    = px - $signed({6'b0, fit.offset_x});
    dy    = py - $signed({6'b0, fit.offset_y});
    rect_ok = (sx1 > sx0) && (sy1 > sy0);
    pix_in  = !dx[EW-1] && (dx < fw_s) && !dy[EW-1] && (dy < fh_s);
    st_in   = (in_i.func == afsm_pkg::FUNC_PIXEL) ? !pix_in : !rect_ok;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= acc;
      v2_q <= v1_q;
      ov_q <= lst_v;
    end
  end

  // input and multiply stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fn1_q  <= in_i.func;
      eob1_q <= in_i.end_of_batch;
      st1_q  <= st_in;
      ax0_q  <= (in_i.func == afsm_pkg::FUNC_PIXEL) ? dx[SW-1:0] : sx0[SW-1:0];
      ay0_q  <= (in_i.func == afsm_pkg::FUNC_PIXEL) ? dy[SW-1:0] : sy0[SW-1:0];
      ax1_q  <= sx1[SW-1:0];
      ay1_q  <= sy1[SW-1:0];

      fn2_q  <= fn1_q;
      eob2_q <= eob1_q;
      st2_q  <= st1_q;
      if (fn1_q == afsm_pkg::FUNC_PIXEL) begin
        nx0_q <= PW'(ax0_q) * PW'(fit.src_width);
        ny0_q <= PW'(ay0_q) * PW'(fit.src_height);
        dx0_q <= fit.fitted_width;
        dy0_q <= fit.fitted_height;
      end else begin
        nx0_q <= PW'(ax0_q) * PW'(fit.fitted_width);
        ny0_q <= PW'(ay0_q) * PW'(fit.fitted_height);
        dx0_q <= fit.src_width;
        dy0_q <= fit.src_height;
      end
      nx1_q <= PW'(ax1_q) * PW'(fit.fitted_width);
      ny1_q <= PW'(ay1_q) * PW'(fit.fitted_height);
    end
  end

  // divider lanes
  afsm_div u_div_x0 (
    .clk_i (clk_i), .adv_i (adv), .num_i (nx0_q), .den_i (dx0_q),
    .quo_o (qx0), .rem_nz_o (rx0_unused)
  );
  afsm_div u_div_y0 (
    .clk_i (clk_i), .adv_i (adv), .num_i (ny0_q), .den_i (dy0_q),
    .quo_o (qy0), .rem_nz_o (ry0_unused)
  );
  afsm_div u_div_x1 (
    .clk_i (clk_i), .adv_i (adv), .num_i (nx1_q), .den_i (fit.src_width),
    .quo_o (qx1), .rem_nz_o (rx1)
  );
  afsm_div u_div_y1 (
    .clk_i (clk_i), .adv_i (adv), .num_i (ny1_q), .den_i (fit.src_height),
    .quo_o (qy1), .rem_nz_o (ry1)
  );

  // side data line matching the divider depth
  for (genvar k = 0; k < SW; k++) begin : g_side
    logic v_in, fn_in, eob_in, st_in_k;
    if (k == 0) begin : g_first
      assign v_in    = v2_q;
      assign fn_in   = fn2_q;
      assign eob_in  = eob2_q;
      assign st_in_k = st2_q;
    end else begin : g_next
      assign v_in    = sd_v_q[k-1];
      assign fn_in   = sd_fn_q[k-1];
      assign eob_in  = sd_eob_q[k-1];
      assign st_in_k = sd_st_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sd_v_q[k] <= 1'b0;
      end else if (adv) begin
        sd_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sd_fn_q[k]  <= fn_in;
        sd_eob_q[k] <= eob_in;
        sd_st_q[k]  <= st_in_k;
      end
    end
  end

  assign lst_v  = sd_v_q[SW-1];
  assign lst_fn = sd_fn_q[SW-1];
  assign lst_st = sd_st_q[SW-1];

  // round ends up, limit to the box and add the offset for rectangles; zero failed results
  always_comb begin
    cx1 = {1'b0, qx1} + (SW + 1)'(rx1);
    cy1 = {1'b0, qy1} + (SW + 1)'(ry1);
    lx1 = (cx1 > {1'b0, fit.fitted_width})  ? fit.fitted_width  : cx1[SW-1:0];
    ly1 = (cy1 > {1'b0, fit.fitted_height}) ? fit.fitted_height : cy1[SW-1:0];
    if (lst_st) begin
      fx0 = '0;
      fy0 = '0;
      fx1 = '0;
      fy1 = '0;
    end else if (lst_fn == afsm_pkg::FUNC_PIXEL) begin
      fx0 = qx0;
      fy0 = qy0;
      fx1 = '0;
      fy1 = '0;
    end else begin
      fx0 = SW'(fit.offset_x) + qx0;
      fy0 = SW'(fit.offset_y) + qy0;
      fx1 = SW'(fit.offset_x) + lx1;
      fy1 = SW'(fit.offset_y) + ly1;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ost_q  <= lst_st;
      oeob_q <= sd_eob_q[SW-1];
      ox0_q  <= fx0;
      oy0_q  <= fy0;
      ox1_q  <= fx1;
      oy1_q  <= fy1;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.status     = ost_q;
  assign out_o.out_x0     = ox0_q;
  assign out_o.out_y0     = oy0_q;
  assign out_o.out_x1     = ox1_q;
  assign out_o.out_y1     = oy1_q;
  assign out_o.batch_done = oeob_q;

  // failed transactions carry an all-zero box
  `AFSM_ASSERT(a_fail_zero, clk_i, rst_ni, (ov_q && ost_q) |-> (ox0_q == '0 && oy0_q == '0 && ox1_q == '0 && oy1_q == '0), "failed result carries coordinates")
  // a frozen pipeline keeps its result transaction
  `AFSM_ASSERT(a_stall_keep, clk_i, rst_ni, (ov_q && !out_o.ready) |=> (ov_q && $stable(ox0_q) && $stable(ox1_q)), "stalled result lost")
  // no request enters while the box is being refitted
  `AFSM_NEVER(a_no_entry_refit, clk_i, rst_ni, fit.busy && in_i.valid && in_i.ready, "request accepted during refit")

endmodule

// ----- tb/sv/aspect_fit_scaler_mapper_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspect_fit_scaler_mapper_tb
// drives random and directed mapping requests through several geometries
// and checks every result against an in-bench letterbox predictor
// ----------------------------------------------------------------------------
module aspect_fit_scaler_mapper_tb;

  typedef struct packed {
    logic              func;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic [15:0]       rect_w;
    logic [15:0]       rect_h;
    logic              eob;
  } req_t;

  typedef struct packed {
    logic              status;
    logic [12:0]       x0;
    logic [12:0]       y0;
    logic [12:0]       x1;
    logic [12:0]       y1;
    logic              done;
  } res_t;

  localparam int MAXS = 4096;
  localparam int IW   = afsm_pkg::IDX_W;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [afsm_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [afsm_pkg::SIDE_W-1:0] cfg_data_i = '0;

  afsm_in_if  req_if ();
  afsm_out_if res_if ();

  aspect_fit_scaler_mapper u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_if.sink), .out_o(res_if.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // geometry copy
  longint src_w, src_h, view_w, view_h, fit_w, fit_h, ofs_x, ofs_y;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   n_errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   stim_done = 0;
  bit   req_accepted = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    n_errors++;
  endtask

  function automatic void refit_box();
    if (view_w * src_h <= view_h * src_w) begin
      fit_w = view_w;
      fit_h = (view_w * src_h) / src_w;
    end else begin
      fit_h = view_h;
      fit_w = (view_h * src_w) / src_h;
    end
    if (fit_w < 1) fit_w = 1;
    if (fit_h < 1) fit_h = 1;
    ofs_x = (view_w - fit_w) / 2;
    ofs_y = (view_h - fit_h) / 2;
  endfunction

  function automatic void write_geometry(input logic [afsm_pkg::IDX_W-1:0] idx,
                                         input logic [12:0] val);
    longint v;
    v = val;
    if (v < 1) v = 1;
    if (v > MAXS) v = MAXS;
    case (idx)
      afsm_pkg::REG_SRC_WIDTH:   src_w = v;
      afsm_pkg::REG_SRC_HEIGHT:  src_h = v;
      afsm_pkg::REG_VIEW_WIDTH:  view_w = v;
      afsm_pkg::REG_VIEW_HEIGHT: view_h = v;
      default: return;
    endcase
    refit_box();
  endfunction

  function automatic res_t map_request(input req_t r);
    res_t o;
    longint px, py, sx0, sy0, sx1, sy1, dx0, dy0, dx1, dy1, dx, dy;
    o = '0;
    o.status = 1'b1;
    o.done = r.eob;
    px = longint'(signed'(r.pos_x));
    py = longint'(signed'(r.pos_y));
    if (r.func == afsm_pkg::FUNC_RECT) begin
      sx0 = px; sy0 = py;
      sx1 = px + longint'(r.rect_w);
      sy1 = py + longint'(r.rect_h);
      if (sx0 < 0) sx0 = 0;
      if (sy0 < 0) sy0 = 0;
      if (sx1 > src_w) sx1 = src_w;
      if (sy1 > src_h) sy1 = src_h;
      if (sx1 > sx0 && sy1 > sy0) begin
        dx0 = ofs_x + (sx0 * fit_w) / src_w;
        dy0 = ofs_y + (sy0 * fit_h) / src_h;
        dx1 = ofs_x + (sx1 * fit_w + src_w - 1) / src_w;
        dy1 = ofs_y + (sy1 * fit_h + src_h - 1) / src_h;
        if (dx0 < ofs_x) dx0 = ofs_x;
        if (dy0 < ofs_y) dy0 = ofs_y;
        if (dx1 > ofs_x + fit_w) dx1 = ofs_x + fit_w;
        if (dy1 > ofs_y + fit_h) dy1 = ofs_y + fit_h;
        o.status = 1'b0;
        o.x0 = dx0[12:0]; o.y0 = dy0[12:0];
        o.x1 = dx1[12:0]; o.y1 = dy1[12:0];
      end
    end else begin
      dx = px - ofs_x;
      dy = py - ofs_y;
      if (dx >= 0 && dx < fit_w && dy >= 0 && dy < fit_h) begin
        o.status = 1'b0;
        o.x0 = 13'((dx * src_w) / fit_w);
        o.y0 = 13'((dy * src_h) / fit_h);
      end
    end
    return o;
  endfunction

  // driver: request channel
  initial begin
    req_if.valid = 1'b0;
    req_if.func = 1'b0;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    req_if.rect_w = '0;
    req_if.rect_h = '0;
    req_if.end_of_batch = 1'b0;
    res_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!req_if.valid || req_accepted) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_t r;
          r = pending_reqs.pop_front();
          req_if.valid <= 1'b1;
          req_if.func <= r.func;
          req_if.pos_x <= r.pos_x;
          req_if.pos_y <= r.pos_y;
          req_if.rect_w <= r.rect_w;
          req_if.rect_h <= r.rect_h;
          req_if.end_of_batch <= r.eob;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    req_accepted <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        req_t r;
        r = {req_if.func, req_if.pos_x, req_if.pos_y, req_if.rect_w, req_if.rect_h,
             req_if.end_of_batch};
        expected_results.push_back(map_request(r));
      end
      if (res_if.valid && res_if.ready) begin
        res_t e;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          e = expected_results.pop_front();
          if (res_if.status !== e.status)
            report_mismatch($sformatf("status %0b exp %0b", res_if.status, e.status));
          if (res_if.out_x0 !== e.x0)
            report_mismatch($sformatf("out_x0 %0d exp %0d", res_if.out_x0, e.x0));
          if (res_if.out_y0 !== e.y0)
            report_mismatch($sformatf("out_y0 %0d exp %0d", res_if.out_y0, e.y0));
          if (res_if.out_x1 !== e.x1)
            report_mismatch($sformatf("out_x1 %0d exp %0d", res_if.out_x1, e.x1));
          if (res_if.out_y1 !== e.y1)
            report_mismatch($sformatf("out_y1 %0d exp %0d", res_if.out_y1, e.y1));
          if (res_if.batch_done !== e.done)
            report_mismatch($sformatf("batch_done %0b exp %0b", res_if.batch_done,
                                      e.done));
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_if.valid || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [afsm_pkg::IDX_W-1:0] idx,
                           input logic [12:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    write_geometry(idx, val);
  endtask

  task automatic set_geometry(input logic [12:0] sw, input logic [12:0] sh,
                              input logic [12:0] vw, input logic [12:0] vh);
    wait_drained();
    repeat (20) @(posedge clk_i);
    cfg_write(afsm_pkg::REG_SRC_WIDTH, sw);
    cfg_write(afsm_pkg::REG_SRC_HEIGHT, sh);
    cfg_write(afsm_pkg::REG_VIEW_WIDTH, vw);
    cfg_write(afsm_pkg::REG_VIEW_HEIGHT, vh);
    // unknown index, must be ignored
    cfg_write(IW'(4 + $urandom_range(3)), 13'($urandom));
  endtask

  function automatic logic [15:0] near_coord(input longint lim);
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'(-longint'($urandom_range(20)));
      2: return 16'(lim - 3 + $urandom_range(6));
      default: return 16'($urandom_range(lim + 4));
    endcase
  endfunction

  task automatic queue_random(input int n);
    req_t r;
    repeat (n) begin
      r.func = $urandom_range(1);
      r.eob = ($urandom_range(7) == 0);
      if (r.func == afsm_pkg::FUNC_RECT) begin
        r.pos_x = near_coord(src_w);
        r.pos_y = near_coord(src_h);
        r.rect_w = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(src_w + 2));
        r.rect_h = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(src_h + 2));
      end else begin
        r.pos_x = near_coord(view_w);
        r.pos_y = near_coord(view_h);
        r.rect_w = 16'($urandom);
        r.rect_h = 16'($urandom);
      end
      pending_reqs.push_back(r);
    end
  endtask

  task automatic queue_one(input logic f, input logic [15:0] x, input logic [15:0] y,
                           input logic [15:0] w, input logic [15:0] h, input logic e);
    pending_reqs.push_back({f, x, y, w, h, e});
  endtask

  // stimulus
  initial begin
    src_w = 640; src_h = 480; view_w = 960; view_h = 720;
    refit_box();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and empty / outside cases at reset geometry
    queue_one(afsm_pkg::FUNC_RECT, 16'd0, 16'd0, 16'd640, 16'd480, 1'b0);
    queue_one(afsm_pkg::FUNC_RECT, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_one(afsm_pkg::FUNC_RECT, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_one(afsm_pkg::FUNC_RECT, 16'd10, 16'd10, 16'd0, 16'd5, 1'b1);
    queue_one(afsm_pkg::FUNC_RECT, 16'd639, 16'd479, 16'd1, 16'd1, 1'b0);
    queue_one(afsm_pkg::FUNC_RECT, 16'hFFFF, 16'hFFFF, 16'd2, 16'd2, 1'b0);
    queue_one(afsm_pkg::FUNC_RECT, 16'd3, 16'd7, 16'd1, 16'd1, 1'b1);
    queue_one(afsm_pkg::FUNC_PIXEL, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    queue_one(afsm_pkg::FUNC_PIXEL, 16'd959, 16'd719, 16'd0, 16'd0, 1'b1);
    queue_one(afsm_pkg::FUNC_PIXEL, 16'd960, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_one(afsm_pkg::FUNC_PIXEL, 16'hFFFF, 16'd5, 16'd0, 16'd0, 1'b0);
    queue_one(afsm_pkg::FUNC_PIXEL, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 1'b1);
    wait_drained();

    // pillarbox geometry with out-of-range values clamped
    set_geometry(13'd0, 13'd8191, 13'd5000, 13'd1);
    queue_one(afsm_pkg::FUNC_PIXEL, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    queue_one(afsm_pkg::FUNC_RECT, 16'd0, 16'd0, 16'd1, 16'd4096, 1'b1);
    queue_one(afsm_pkg::FUNC_PIXEL, 16'd2048, 16'd0, 16'd0, 16'd0, 1'b0);
    send_idle_pct = 30; recv_idle_pct = 71;
    queue_random(150);
    wait_drained();

    set_geometry(13'd4096, 13'd1, 13'd1, 13'd4096);
    queue_random(150);
    wait_drained();

    send_idle_pct = 71; recv_idle_pct = 30;
    set_geometry(13'd320, 13'd200, 13'd1920, 13'd1080);
    queue_random(150);
    wait_drained();
    set_geometry(13'd4096, 13'd4096, 13'd4096, 13'd4096);
    queue_random(150);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    set_geometry(13'd7, 13'd3, 13'd11, 13'd13);
    queue_random(150);
    wait_drained();
    repeat (3) begin
      set_geometry(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                   13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
      queue_random(150);
      wait_drained();
    end
    stim_done = 1;
  end

  // end of run
  initial begin
    wait (stim_done);
    repeat (40) @(posedge clk_i);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/afsm_pkg.sv
hdl/afsm_in_if.sv
hdl/afsm_out_if.sv
hdl/afsm_div.sv
hdl/afsm_fit.sv
hdl/aspect_fit_scaler_mapper.sv
tb/sv/aspect_fit_scaler_mapper_tb.sv
